>>> rtl/bbc_pkg.sv
// Shared types and constants for the bracket balance checker.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package bbc_pkg;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned LEVEL_W     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned PTR_W       = $clog2(STACK_DEPTH);
  localparam int unsigned MAXD_W      = 6;
  localparam int unsigned CMP_W       = (LEVEL_W > MAXD_W) ? LEVEL_W : MAXD_W;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_OPEN_PAREN   = 8'h28;
  localparam logic [7:0] CH_CLOSE_PAREN  = 8'h29;
  localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
  localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
  localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
  localparam logic [7:0] CH_NUL          = 8'h00;

  localparam logic [MAXD_W-1:0] MAX_DEPTH_RST = MAXD_W'(30);

  typedef enum logic [1:0] {
    BR_PAREN  = 2'd0,
    BR_SQUARE = 2'd1,
    BR_CURLY  = 2'd2,
    BR_UNUSED = 2'd3
  } br_code_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUSH,
    OP_POP,
    OP_STOP
  } op_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_MISMATCH  = 3'd1,
    ERR_UNDERFLOW = 3'd2,
    ERR_OVERFLOW  = 3'd3,
    ERR_UNCLOSED  = 3'd4
  } err_e;

  typedef enum logic {
    CFG_MAX_DEPTH       = 1'b0,
    CFG_USE_DEPTH_LIMIT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    op_e      op;
    br_code_e code;
    logic     last;
  } item_t;

  typedef struct packed {
    logic [MAXD_W-1:0] max_depth;
    logic              use_depth_limit;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/bbc_front.sv
// Front stage: accepts text bytes and decodes them into stack operations.
// Depends on bbc_pkg.
`default_nettype none

module bbc_front
  import bbc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] text_byte_i,
  input  wire logic       last_byte_i,
  output logic            item_valid_o,
  input  wire logic       item_ready_i,
  output item_t           item_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  take;

  assign in_ready_o = !valid_q || item_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    item_d.last = last_byte_i;
    item_d.op   = OP_NONE;
    item_d.code = BR_PAREN;
    unique case (text_byte_i)
      CH_NUL:          item_d.op = OP_STOP;
      CH_OPEN_PAREN:   begin item_d.op = OP_PUSH; item_d.code = BR_PAREN;  end
      CH_OPEN_SQUARE:  begin item_d.op = OP_PUSH; item_d.code = BR_SQUARE; end
      CH_OPEN_CURLY:   begin item_d.op = OP_PUSH; item_d.code = BR_CURLY;  end
      CH_CLOSE_PAREN:  begin item_d.op = OP_POP;  item_d.code = BR_PAREN;  end
      CH_CLOSE_SQUARE: begin item_d.op = OP_POP;  item_d.code = BR_SQUARE; end
      CH_CLOSE_CURLY:  begin item_d.op = OP_POP;  item_d.code = BR_CURLY;  end
      default:         item_d.op = OP_NONE;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (item_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

>>> rtl/bbc_queue.sv
// Short FIFO of decoded operations between the front and back stages.
// Depends on bbc_pkg.
`default_nettype none

module bbc_queue
  import bbc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  wr_valid_i,
  output logic       wr_ready_o,
  input  wire item_t wr_item_i,
  output logic       rd_valid_o,
  input  wire logic  rd_ready_i,
  output item_t      rd_item_o
);

  localparam int unsigned QP_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QC_W = $clog2(QUEUE_DEPTH + 1);

  item_t           slot_q [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QC_W-1:0] count_q, count_d;
  logic            push, pop;

  assign wr_ready_o = (count_q != QC_W'(QUEUE_DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bbc_back.sv
// Back stage: runs stack operations on the bracket stack and forms the verdict.
// Depends on bbc_pkg.
`default_nettype none

module bbc_back
  import bbc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  item_valid_i,
  output logic       item_ready_o,
  input  wire item_t item_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output logic       balanced_o,
  output logic [2:0] error_kind_o
);

  br_code_e stack_q [STACK_DEPTH];

  logic [LEVEL_W-1:0] level_q, level_d, level_s;
  err_e               fail_q, fail_d, fail_s;
  logic               stop_q, stop_d, stop_s;
  logic               out_valid_q, out_valid_d;
  logic               bal_q, bal_d;
  err_e               kind_q, kind_d;

  logic               out_free, exec, push_we;
  logic [CMP_W-1:0]   limit, level_ext;
  logic [PTR_W-1:0]   top_idx;

  assign out_free     = !out_valid_q || out_ready_i;
  assign exec         = item_valid_i && (!item_i.last || out_free);
  assign item_ready_o = exec;

  always_comb begin
    limit = CMP_W'(STACK_DEPTH);
    if (cfg_i.use_depth_limit && (CMP_W'(cfg_i.max_depth) < CMP_W'(STACK_DEPTH))) begin
      limit = CMP_W'(cfg_i.max_depth);
    end
  end

  assign level_ext = CMP_W'(level_q);
  assign top_idx   = PTR_W'(level_q - 1'b1);

  // Scan the operation, then form the verdict and clear on the last byte.
  always_comb begin
    level_s = level_q;
    fail_s  = fail_q;
    stop_s  = stop_q;
    push_we = 1'b0;
    if (exec && !stop_q && (fail_q == ERR_NONE)) begin
      unique case (item_i.op)
        OP_STOP: stop_s = 1'b1;
        OP_PUSH: begin
          if (level_ext >= limit) begin
            fail_s = ERR_OVERFLOW;
          end else begin
            push_we = 1'b1;
            level_s = level_q + 1'b1;
          end
        end
        OP_POP: begin
          if (level_q == '0) begin
            fail_s = ERR_UNDERFLOW;
          end else begin
            level_s = level_q - 1'b1;
            if (stack_q[top_idx] != item_i.code) begin
              fail_s = ERR_MISMATCH;
            end
          end
        end
        default: ;
      endcase
    end

    level_d     = level_s;
    fail_d      = fail_s;
    stop_d      = stop_s;
    out_valid_d = out_valid_q && !out_ready_i;
    bal_d       = bal_q;
    kind_d      = kind_q;
    if (exec && item_i.last) begin
      out_valid_d = 1'b1;
      if (fail_s != ERR_NONE) begin
        bal_d  = 1'b0;
        kind_d = fail_s;
      end else if (level_s != '0) begin
        bal_d  = 1'b0;
        kind_d = ERR_UNCLOSED;
      end else begin
        bal_d  = 1'b1;
        kind_d = ERR_NONE;
      end
      level_d = '0;
      fail_d  = ERR_NONE;
      stop_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      fail_q      <= ERR_NONE;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      level_q     <= level_d;
      fail_q      <= fail_d;
      stop_q      <= stop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_we) begin
      stack_q[level_q[PTR_W-1:0]] <= item_i.code;
    end
    if (exec && item_i.last) begin
      bal_q  <= bal_d;
      kind_q <= kind_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign balanced_o   = bal_q;
  assign error_kind_o = kind_q;

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LEVEL_W'(STACK_DEPTH))
    else $error("stack level beyond physical depth");

  a_clear_after_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && item_i.last) |=> (level_q == '0 && fail_q == ERR_NONE && !stop_q && out_valid_q))
    else $error("state not cleared after verdict");

  a_no_unclosed_failure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fail_q != ERR_UNCLOSED)
    else $error("unclosed recorded as scan failure");

  a_balanced_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && bal_q) |-> (kind_q == ERR_NONE))
    else $error("balanced verdict with error kind");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !(exec && item_i.last))
    else $error("verdict overwritten while stalled");

endmodule

`default_nettype wire

>>> rtl/bracket_balance_checker_core.sv
// Top level of the bracket balance checker: configuration registers and stages.
// Depends on bbc_pkg, bbc_front, bbc_queue and bbc_back.
//
// Usage: text bytes enter on the in channel (in_valid_i / in_ready_o) with
// last_byte_i marking the final byte of a string. Opening brackets (, [ and {
// push onto a 32-entry stack, closing brackets pop and must match. The first
// failure (mismatch, underflow, overflow) freezes the verdict; a zero byte
// stops scanning. One verdict per string leaves on the out channel
// (out_valid_o / out_ready_i) as balanced_o and error_kind_o. Throughput: one
// byte per cycle, set by the back stage's single stack push or pop each cycle,
// while no held verdict stalls a last byte. Bytes pass the front register, a
// queue slot and the back stage. When the receiver stalls, the verdict is held
// in the output register and bytes keep flowing until the next last byte
// reaches the back stage and the two-entry queue and front register fill.
// Reset empties all stages, clears the scan state and sets max_depth to 30
// with the depth limit enabled. The user must write configuration (cfg_we_i,
// cfg_index_i, cfg_wdata_i) only while idle; the block does not enforce it.
`default_nettype none

module bracket_balance_checker_core
  import bbc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_index_i,
  input  wire logic [MAXD_W-1:0] cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        text_byte_i,
  input  wire logic              last_byte_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   balanced_o,
  output logic [2:0]             error_kind_o
);

  cfg_t  cfg_q, cfg_d;
  logic  fr_valid, fr_ready, bk_valid, bk_ready;
  item_t fr_item, bk_item;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MAX_DEPTH:       cfg_d.max_depth       = cfg_wdata_i;
        CFG_USE_DEPTH_LIMIT: cfg_d.use_depth_limit = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_depth       <= MAX_DEPTH_RST;
      cfg_q.use_depth_limit <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  bbc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .text_byte_i  (text_byte_i),
    .last_byte_i  (last_byte_i),
    .item_valid_o (fr_valid),
    .item_ready_i (fr_ready),
    .item_o       (fr_item)
  );

  bbc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_item_i  (fr_item),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready),
    .rd_item_o  (bk_item)
  );

  bbc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (bk_valid),
    .item_ready_o (bk_ready),
    .item_i       (bk_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .balanced_o   (balanced_o),
    .error_kind_o (error_kind_o)
  );

endmodule

`default_nettype wire
